// ===== rtl/core/lbw_pkg.sv =====
// shared constants and types of the least-loaded worker balancer
// worker count, index and load widths, status codes, register indexes and reset values, mode and fsm codes
// no dependencies
package lbw_pkg;

	localparam int MAX_WORKERS = 16;
	// index width of the load memory
	localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	// counter width, holds MAX_WORKERS itself
	localparam int CW = $clog2(MAX_WORKERS + 1);

	localparam int LOAD_W = 16;
	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

	typedef enum logic [2:0] {
		ST_GRANTED      = 3'd0,
		ST_WORKERS_FULL = 3'd1,
		ST_ACCEPT_FULL  = 3'd2,
		ST_RELEASED     = 3'd3,
		ST_RELEASE_ERR  = 3'd4
	} status_t;

	localparam logic [1:0] REG_BALANCED_MODE    = 2'd0;
	localparam logic [1:0] REG_WORKERS_IN_USE   = 2'd1;
	localparam logic [1:0] REG_PER_WORKER_LIMIT = 2'd2;
	localparam logic [1:0] REG_ACCEPT_LIMIT     = 2'd3;

	localparam logic        RST_BALANCED_MODE    = 1'b1;
	localparam logic [4:0]  RST_WORKERS_IN_USE   = 5'd16;
	localparam logic [15:0] RST_PER_WORKER_LIMIT = 16'd1024;
	localparam logic [15:0] RST_ACCEPT_LIMIT     = 16'd4096;

	localparam logic MODE_ASSIGN  = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_DEC  = 5'b00100,
		S_RREL = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

endpackage

// ===== rtl/core/least_loaded_worker_balancer.sv =====
// least-loaded worker balancer: request channel in, one result per request out
// per-worker open counts live in an lbw_ram with valid bits; uses lbw_pkg
//
// usage: a request carries mode on s_axis_tuser (0 assign, 1 release) and the
// worker to release on s_axis_tdata. every request yields exactly one result
// on the m_axis channel: status on m_axis_tuser, chosen worker and the open
// total after the event on m_axis_tdata.
// one request is worked on at a time; s_axis_tready is high while idle.
// an assign scans the load memory one worker per cycle through its single
// read port, n = min(workers_in_use, MAX_WORKERS) workers in all; a release
// reads and writes back one counter; an assign refused at once does not scan.
// results sit in an output register, so the next request is taken while
// a result still waits; if the receiver stalls, the following result is
// held in the block until the output register frees up.
// asynchronous reset clears all counts at once through per-entry valid
// bits (no clearing pass), restores the registers to their reset values and
// drops the output valid. the user must see that configuration is written
// only while idle; the block itself does not enforce it.
module least_loaded_worker_balancer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [3:0] release_worker, [7:4] zero
	input  logic [0:0]  s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [3:0] chosen_worker, [19:4] open_total, [23:20] zero
	output logic [2:0]  m_axis_tuser    // [2:0] status
);

	localparam int WIDX = lbw_pkg::WIDX;
	localparam int CW   = lbw_pkg::CW;
	localparam int NW   = (CW > 5) ? CW : 5;
	localparam int LW   = lbw_pkg::LOAD_W;

	// configuration
	logic          balanced_q;
	logic [4:0]    wiu_q;
	logic [LW-1:0] pw_limit_q;
	logic [LW-1:0] acc_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balanced_q  <= lbw_pkg::RST_BALANCED_MODE;
			wiu_q       <= lbw_pkg::RST_WORKERS_IN_USE;
			pw_limit_q  <= lbw_pkg::RST_PER_WORKER_LIMIT;
			acc_limit_q <= lbw_pkg::RST_ACCEPT_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbw_pkg::REG_BALANCED_MODE:    balanced_q  <= cfg_data[0];
				lbw_pkg::REG_WORKERS_IN_USE:   wiu_q       <= cfg_data[4:0];
				lbw_pkg::REG_PER_WORKER_LIMIT: pw_limit_q  <= cfg_data;
				lbw_pkg::REG_ACCEPT_LIMIT:     acc_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// number of workers scanned
	logic [NW-1:0] wiu_ext;
	logic [NW-1:0] n_ext;
	logic [CW-1:0] n_act;
	assign wiu_ext = NW'(wiu_q);
	assign n_ext   = (wiu_ext > NW'(lbw_pkg::MAX_WORKERS)) ? NW'(lbw_pkg::MAX_WORKERS) : wiu_ext;
	assign n_act   = CW'(n_ext);

	lbw_pkg::state_t state_q;
	logic            accept;
	logic            in_mode;
	logic [3:0]      in_rw;
	logic            rw_bad;
	logic [WIDX-1:0] rel_addr;

	assign s_axis_tready = (state_q == lbw_pkg::S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_mode       = s_axis_tuser[0];
	assign in_rw         = s_axis_tdata[3:0];
	assign rw_bad        = 32'(in_rw) >= 32'(lbw_pkg::MAX_WORKERS);
	assign rel_addr      = WIDX'(in_rw);

	logic [CW-1:0]   cnt_q;
	logic            vld_s1;
	logic            last_s1;
	logic [WIDX-1:0] addr_s1;
	logic            found_q;
	logic [WIDX-1:0] sel_q;
	logic [LW-1:0]   sel_load_q;
	logic [3:0]      rel_idx_q;
	logic [LW-1:0]   total_q;
	logic [lbw_pkg::MAX_WORKERS-1:0] valid_q;

	// result waiting for the output register
	lbw_pkg::status_t res_status_q;
	logic [3:0]       res_chosen_q;
	logic [LW-1:0]    res_total_q;

	logic [2:0]  out_status_q;
	logic [3:0]  out_chosen_q;
	logic [LW-1:0] out_total_q;
	logic        out_valid_q;

	// load memory
	logic            ram_we;
	logic [WIDX-1:0] ram_waddr;
	logic [LW-1:0]   ram_wdata;
	logic [WIDX-1:0] ram_raddr;
	logic [LW-1:0]   ram_rdata;
	logic [LW-1:0]   load;

	lbw_ram #(
		.WIDTH (LW),
		.DEPTH (lbw_pkg::MAX_WORKERS)
	) u_load_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// entries never written since reset read as zero
	assign load = valid_q[addr_s1] ? ram_rdata : '0;

	always_comb begin
		priority case (1'b1)
			state_q == lbw_pkg::S_IDLE: ram_raddr = (in_mode == lbw_pkg::MODE_RELEASE) ?
				rel_addr : '0;
			default: ram_raddr = cnt_q[WIDX-1:0];
		endcase
	end

	logic grant;
	assign grant = found_q && (sel_load_q < pw_limit_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sel_q;
		ram_wdata = (sel_load_q == lbw_pkg::LOAD_MAX) ? sel_load_q : sel_load_q + 1'b1;
		if (state_q == lbw_pkg::S_DEC) begin
			ram_we = grant;
		end else if (state_q == lbw_pkg::S_RREL) begin
			ram_we    = (load != '0);
			ram_waddr = addr_s1;
			ram_wdata = load - 1'b1;
		end
	end

	logic out_push;
	assign out_push = (state_q == lbw_pkg::S_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbw_pkg::S_IDLE;
			total_q <= '0;
			valid_q <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				lbw_pkg::S_IDLE: begin
					if (accept) begin
						rel_idx_q <= in_rw;
						if (in_mode == lbw_pkg::MODE_RELEASE) begin
							if (rw_bad) begin
								res_status_q <= lbw_pkg::ST_RELEASE_ERR;
								res_chosen_q <= in_rw;
								res_total_q  <= total_q;
								state_q      <= lbw_pkg::S_DONE;
							end else begin
								addr_s1 <= rel_addr;
								state_q <= lbw_pkg::S_RREL;
							end
						end else if (total_q >= acc_limit_q) begin
							res_status_q <= lbw_pkg::ST_ACCEPT_FULL;
							res_chosen_q <= '0;
							res_total_q  <= total_q;
							state_q      <= lbw_pkg::S_DONE;
						end else if (n_act == '0) begin
							res_status_q <= lbw_pkg::ST_WORKERS_FULL;
							res_chosen_q <= '0;
							res_total_q  <= total_q;
							state_q      <= lbw_pkg::S_DONE;
						end else begin
							// worker 0 is read at this edge
							addr_s1 <= '0;
							vld_s1  <= 1'b1;
							last_s1 <= (n_act == CW'(1));
							cnt_q   <= CW'(1);
							found_q <= 1'b0;
							state_q <= lbw_pkg::S_SCAN;
						end
					end
				end
				lbw_pkg::S_SCAN: begin
					// on the last worker cnt_q has reached n_act, so vld_s1 drops
					addr_s1 <= cnt_q[WIDX-1:0];
					vld_s1  <= (cnt_q < n_act);
					last_s1 <= (cnt_q == CW'(n_act - 1'b1));
					if (cnt_q < n_act) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (vld_s1) begin
						// strict less keeps the lowest index among equal loads
						if (balanced_q ? (!found_q || load < sel_load_q)
						               : (!found_q && load < pw_limit_q)) begin
							found_q    <= 1'b1;
							sel_q      <= addr_s1;
							sel_load_q <= load;
						end
						if (last_s1) begin
							state_q <= lbw_pkg::S_DEC;
						end
					end
				end
				lbw_pkg::S_DEC: begin
					if (grant) begin
						valid_q[sel_q] <= 1'b1;
						if (total_q != lbw_pkg::LOAD_MAX) begin
							total_q <= total_q + 1'b1;
						end
						res_status_q <= lbw_pkg::ST_GRANTED;
						res_chosen_q <= 4'(sel_q);
						res_total_q  <= (total_q == lbw_pkg::LOAD_MAX) ? total_q
						                                              : total_q + 1'b1;
					end else begin
						res_status_q <= lbw_pkg::ST_WORKERS_FULL;
						res_chosen_q <= '0;
						res_total_q  <= total_q;
					end
					state_q <= lbw_pkg::S_DONE;
				end
				lbw_pkg::S_RREL: begin
					res_chosen_q <= rel_idx_q;
					if (load == '0) begin
						res_status_q <= lbw_pkg::ST_RELEASE_ERR;
						res_total_q  <= total_q;
					end else begin
						valid_q[addr_s1] <= 1'b1;
						res_status_q     <= lbw_pkg::ST_RELEASED;
						if (total_q != '0) begin
							total_q     <= total_q - 1'b1;
							res_total_q <= total_q - 1'b1;
						end else begin
							res_total_q <= total_q;
						end
					end
					state_q <= lbw_pkg::S_DONE;
				end
				lbw_pkg::S_DONE: begin
					if (out_push) begin
						state_q <= lbw_pkg::S_IDLE;
					end
				end
				default: state_q <= lbw_pkg::S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_status_q <= res_status_q;
			out_chosen_q <= res_chosen_q;
			out_total_q  <= res_total_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {4'b0, out_total_q, out_chosen_q};

endmodule

// ===== rtl/core/lbw_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lbw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== verif/tb.sv =====
// self-checking bench for least_loaded_worker_balancer: directed requests, then random phases
// predicts status, chosen worker and open total per request and checks each result in order
// depends on lbw_pkg and the balancer rtl
module tb;

	typedef struct {
		logic       mode;
		logic [3:0] worker;
	} conn_req_t;

	typedef struct {
		lbw_pkg::status_t status;
		logic [3:0]       worker;
		logic [15:0]      total;
	} conn_result_t;

	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = lbw_pkg::REG_BALANCED_MODE;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [3:0] release_worker, [7:4] zero
	logic [0:0]  s_axis_tuser = '0;   // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [23:0] m_axis_tdata;        // [3:0] chosen_worker, [19:4] open_total, [23:20] zero
	logic [2:0]  m_axis_tuser;        // [2:0] status

	// shadow of the block's registers and counters
	logic        sh_balanced = lbw_pkg::RST_BALANCED_MODE;
	logic [4:0]  sh_workers = lbw_pkg::RST_WORKERS_IN_USE;
	logic [15:0] sh_worker_limit = lbw_pkg::RST_PER_WORKER_LIMIT;
	logic [15:0] sh_accept_limit = lbw_pkg::RST_ACCEPT_LIMIT;
	logic [15:0] sh_load [lbw_pkg::MAX_WORKERS];
	logic [15:0] sh_total = '0;

	conn_req_t    req_q[$];
	conn_result_t result_q[$];

	logic in_taken = 1'b0;
	bit   calm = 1'b0;
	int   src_idle = 0;
	int   dst_idle = 0;
	int   mismatches = 0;
	int   stall_cycles = 0;
	// requests handed to the bus and results seen, for draining
	int   sent_cnt = 0;
	int   done_cnt = 0;

	least_loaded_worker_balancer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < lbw_pkg::MAX_WORKERS; i++) sh_load[i] = '0;
	end

	// applies one request to the shadow counters and returns the result it should give
	function automatic conn_result_t balance_event(input logic mode, input logic [3:0] wk);
		conn_result_t r;
		int n;
		int best;
		int i;
		bit found;
		r.worker = '0;
		r.status = lbw_pkg::ST_GRANTED;
		if (mode == lbw_pkg::MODE_ASSIGN) begin
			n = (sh_workers > lbw_pkg::MAX_WORKERS) ? lbw_pkg::MAX_WORKERS : sh_workers;
			best = 0;
			found = 1'b0;
			if (sh_total >= sh_accept_limit) begin
				r.status = lbw_pkg::ST_ACCEPT_FULL;
			end else begin
				if (n > 0 && sh_balanced) begin
					for (i = 1; i < n; i++)
						if (sh_load[i] < sh_load[best]) best = i;
					found = sh_load[best] < sh_worker_limit;
				end else begin
					for (i = 0; i < n && !found; i++) begin
						if (sh_load[i] < sh_worker_limit) begin
							best = i;
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					r.status = lbw_pkg::ST_WORKERS_FULL;
				end else begin
					if (sh_load[best] != lbw_pkg::LOAD_MAX)
						sh_load[best] = sh_load[best] + 1'b1;
					if (sh_total != 16'hFFFF) sh_total = sh_total + 1'b1;
					r.worker = best[3:0];
				end
			end
		end else begin
			r.worker = wk;
			if (int'(wk) >= lbw_pkg::MAX_WORKERS || sh_load[wk] == '0) begin
				r.status = lbw_pkg::ST_RELEASE_ERR;
			end else begin
				sh_load[wk] = sh_load[wk] - 1'b1;
				if (sh_total != '0) sh_total = sh_total - 1'b1;
				r.status = lbw_pkg::ST_RELEASED;
			end
		end
		r.total = sh_total;
		return r;
	endfunction

	// request driver
	always @(negedge clk) begin
		conn_req_t item;
		if (arst_n) begin
			if (!(s_axis_tvalid && !in_taken)) begin
				if (src_idle > 0) begin
					src_idle--;
					s_axis_tvalid <= 1'b0;
				end else if (req_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
					src_idle = $urandom_range(0, 15);
					s_axis_tvalid <= 1'b0;
				end else if (req_q.size() > 0) begin
					item = req_q.pop_front();
					sent_cnt++;
					s_axis_tdata <= {4'b0, item.worker};
					s_axis_tuser <= item.mode;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (dst_idle > 0) begin
				dst_idle--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				dst_idle = $urandom_range(0, 15);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// result monitor, prediction and watchdog
	always @(posedge clk) begin
		conn_result_t exp_r;
		bit s_fire;
		bit m_fire;
		s_fire = arst_n && s_axis_tvalid && s_axis_tready;
		m_fire = arst_n && m_axis_tvalid && m_axis_tready;
		in_taken <= s_fire;
		if (m_fire) begin
			done_cnt++;
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d worker %0d total %0d",
						m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]);
			end else begin
				exp_r = result_q.pop_front();
				if (m_axis_tuser !== exp_r.status || m_axis_tdata[3:0] !== exp_r.worker ||
						m_axis_tdata[19:4] !== exp_r.total) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected status %0d worker %0d total %0d, ",
							"got status %0d worker %0d total %0d"},
							exp_r.status, exp_r.worker, exp_r.total,
							m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]);
				end
			end
		end
		if (s_fire)
			result_q.push_back(balance_event(s_axis_tuser[0], s_axis_tdata[3:0]));
		if (s_fire || m_fire || cfg_we || !arst_n) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic push_req(input logic mode, input logic [3:0] wk);
		conn_req_t item;
		item.mode = mode;
		item.worker = wk;
		req_q.push_back(item);
	endtask

	// wait until every request went out and every result came back; ends on a falling edge
	task automatic drain();
		do @(negedge clk);
		while (req_q.size() > 0 || sent_cnt != done_cnt || result_q.size() > 0);
	endtask

	task automatic reconfigure(input logic bal, input logic [4:0] wiu, input logic [15:0] pwl,
			input logic [15:0] acl);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= lbw_pkg::REG_BALANCED_MODE;
		cfg_data <= {15'b0, bal};
		sh_balanced = bal;
		@(negedge clk);
		cfg_index <= lbw_pkg::REG_WORKERS_IN_USE;
		cfg_data <= {11'b0, wiu};
		sh_workers = wiu;
		@(negedge clk);
		cfg_index <= lbw_pkg::REG_PER_WORKER_LIMIT;
		cfg_data <= pwl;
		sh_worker_limit = pwl;
		@(negedge clk);
		cfg_index <= lbw_pkg::REG_ACCEPT_LIMIT;
		cfg_data <= acl;
		sh_accept_limit = acl;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random traffic, releases mostly aimed at the workers in use
	task automatic random_traffic(input int count);
		int n;
		int assign_pct;
		logic [3:0] wk;
		n = (sh_workers > lbw_pkg::MAX_WORKERS) ? lbw_pkg::MAX_WORKERS : sh_workers;
		assign_pct = $urandom_range(35, 65);
		for (int i = 0; i < count; i++) begin
			if (n > 0 && $urandom_range(0, 99) < 85) wk = 4'($urandom_range(0, n - 1));
			else wk = 4'($urandom_range(0, lbw_pkg::MAX_WORKERS - 1));
			if ($urandom_range(0, 99) < assign_pct) push_req(lbw_pkg::MODE_ASSIGN, wk);
			else push_req(lbw_pkg::MODE_RELEASE, wk);
		end
	endtask

	initial begin
		logic [4:0]  wiu;
		logic [15:0] pwl;
		logic [15:0] acl;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: balanced spread, idle release, double release
		repeat (4) push_req(lbw_pkg::MODE_ASSIGN, 4'd0);
		push_req(lbw_pkg::MODE_RELEASE, 4'd1);
		push_req(lbw_pkg::MODE_ASSIGN, 4'd15);
		push_req(lbw_pkg::MODE_RELEASE, 4'd15);
		push_req(lbw_pkg::MODE_RELEASE, 4'd0);
		push_req(lbw_pkg::MODE_RELEASE, 4'd0);
		push_req(lbw_pkg::MODE_RELEASE, 4'd10);

		// accept check wins over a full worker
		reconfigure(1'b1, 5'd16, 16'd0, 16'd0);
		push_req(lbw_pkg::MODE_ASSIGN, 4'd0);
		push_req(lbw_pkg::MODE_RELEASE, 4'd3);
		push_req(lbw_pkg::MODE_ASSIGN, 4'd15);

		// no workers in use
		reconfigure(1'b0, 5'd0, 16'hFFFF, 16'hFFFF);
		push_req(lbw_pkg::MODE_ASSIGN, 4'd0);
		push_req(lbw_pkg::MODE_ASSIGN, 4'd5);
		push_req(lbw_pkg::MODE_RELEASE, 4'd2);

		// balanced pick at a zero worker limit
		reconfigure(1'b1, 5'd16, 16'd0, 16'hFFFF);
		push_req(lbw_pkg::MODE_ASSIGN, 4'd0);

		// more workers than the block has, first fit
		reconfigure(1'b0, 5'd31, 16'hFFFF, 16'hFFFF);
		repeat (3) push_req(lbw_pkg::MODE_ASSIGN, 4'd0);
		push_req(lbw_pkg::MODE_RELEASE, 4'd15);

		reconfigure(1'b1, 5'd16, 16'd4, 16'hFFFF);
		random_traffic(155);
		reconfigure(1'b0, 5'd16, 16'd3, 16'd30);
		random_traffic(155);
		reconfigure(1'b1, 5'd31, 16'd2, 16'hFFFF);
		random_traffic(155);
		reconfigure(1'b0, 5'd0, 16'd5, 16'hFFFF);
		random_traffic(60);
		reconfigure(1'b1, 5'd1, 16'hFFFF, 16'd20);
		random_traffic(155);
		reconfigure(1'b0, 5'd5, 16'd0, 16'hFFFF);
		random_traffic(100);
		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 3))
				0: wiu = 5'($urandom_range(1, 4));
				1: wiu = 5'($urandom_range(5, 16));
				2: wiu = 5'd16;
				default: wiu = 5'($urandom_range(0, 31));
			endcase
			pwl = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 8));
			acl = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40));
			if (p >= 6) calm = 1'b1;
			reconfigure(1'($urandom_range(0, 1)), wiu, pwl, acl);
			random_traffic(137);
		end

		drain();
		repeat (40) @(posedge clk);
		if (result_q.size() > 0) mismatches++;
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== least_loaded_worker_balancer.f =====
rtl/core/lbw_pkg.sv
rtl/core/lbw_ram.sv
rtl/core/least_loaded_worker_balancer.sv
verif/tb.sv
